>>> design/iqsl_pkg.sv
// Shared types and constants for the indexed queue/stack/list unit.
// Holds operation codes, FSM states, field widths and register map.
// No dependencies.
package iqsl_pkg;

	// Field widths
	localparam int FUNC_W  = 4;
	localparam int DATA_W  = 32;
	localparam int INDEX_W = 8;
	localparam int SIZE_W  = 9;
	localparam int CAP_W   = 9;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

	// Default store depth
	localparam int DEPTH_DEF = 256;

	// Operation codes
	typedef enum logic [FUNC_W-1:0] {
		OP_PUSH       = 4'd0,
		OP_POP_FRONT  = 4'd1,
		OP_PEEK_FRONT = 4'd2,
		OP_POP_BACK   = 4'd3,
		OP_PEEK_BACK  = 4'd4,
		OP_GET        = 4'd5,
		OP_DELETE     = 4'd6,
		OP_CONTAINS   = 4'd7,
		OP_CLEAR      = 4'd8
	} op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MOVE,
		ST_APPEND,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

>>> design/indexed_queue_stack_list_unit.sv
// Top level of the indexed queue/stack/list unit: slot memory and sequencer.
// Depends on iqsl_pkg for codes, states and widths.
//
//   channel   direction  handshake              payload
//   request   in         in_valid / in_ready    func, value, index
//   result    out        out_valid / out_ready  data, valid_res, overflow, size, is_empty
//   config    in         psel/penable/pready    paddr, pwrite, pwdata, prdata
//
// Push, clear and misses finish straight from idle; pop, peek and get pass through one memory
// read; delete moves each entry behind the index; contains compares entries from the front
// until a match; a compacting push moves every live entry, then appends. The single read and
// single write port of the slot memory pace this: one entry moves or compares per cycle.
// Reset clears the pointers, the sequencer and sets capacity to 256; slots are not cleared.
// A held result sits in the output register; a finished result that finds it full waits
// in a pending register, and no request is taken until it moves out.
module indexed_queue_stack_list_unit
	import iqsl_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [FUNC_W-1:0]     func,
	input  logic [DATA_W-1:0]     value,
	input  logic [INDEX_W-1:0]    index,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_W-1:0]     data,
	output logic                  valid_res,
	output logic                  overflow,
	output logic [SIZE_W-1:0]     size,
	output logic                  is_empty,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW = $clog2(DEPTH + 1);
	localparam int CW = (PW > INDEX_W) ? PW : INDEX_W;
	localparam int KW = (PW > CAP_W) ? PW : CAP_W;
	localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

	state_t state_q, state_d;

	logic [PW-1:0]     front_q, front_d, back_q, back_d;
	logic [CAP_W-1:0]  cap_q;
	logic [DATA_W-1:0] val_q, val_d;
	logic [PW-1:0]     src_q, src_d, dst_q, dst_d, end_q, end_d, rsize_q, rsize_d;
	logic              compact_q, compact_d;

	// slot memory
	logic [DATA_W-1:0] mem [DEPTH];
	logic              mem_we, mem_re;
	logic [PW-1:0]     wptr, rptr;
	logic [DATA_W-1:0] mem_wdata, mem_rdata_s1;

	// result path
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q, pend_data_q, res_data;
	logic              out_vres_q, pend_vres_q, res_valid;
	logic              out_ovf_q, pend_ovf_q, res_ovf;
	logic [PW-1:0]     out_size_q, pend_size_q, res_size;
	logic              fin, out_free, load_out, load_pend;

	// derived values
	logic [PW-1:0]     n, cap_use, idx_addr, del_src;
	logic [KW-1:0]     cap_k;
	logic [CW-1:0]     idx_ext, n_ext;
	logic              idx_ok, cfg_wr;

	// Clamp capacity into 1..DEPTH
	always_comb begin
		cap_k = KW'(cap_q);
		if (cap_q == '0) begin
			cap_use = PW'(1);
		end else if (cap_k > KW'(DEPTH)) begin
			cap_use = DEPTH_P;
		end else begin
			cap_use = PW'(cap_k);
		end
	end

	assign n        = back_q - front_q;
	assign idx_ext  = CW'(index);
	assign n_ext    = CW'(n);
	assign idx_ok   = idx_ext < n_ext;
	assign idx_addr = PW'(CW'(front_q) + idx_ext);
	assign del_src  = idx_addr + PW'(1);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	// Sequencer: next state, memory controls and result
	always_comb begin
		state_d   = state_q;
		front_d   = front_q;
		back_d    = back_q;
		val_d     = val_q;
		src_d     = src_q;
		dst_d     = dst_q;
		end_d     = end_q;
		compact_d = compact_q;
		rsize_d   = rsize_q;
		mem_we    = 1'b0;
		wptr      = '0;
		mem_wdata = val_q;
		mem_re    = 1'b0;
		rptr      = '0;
		fin       = 1'b0;
		res_data  = '0;
		res_valid = 1'b0;
		res_ovf   = 1'b0;
		res_size  = n;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					val_d = value;
					unique case (func) inside
						OP_PUSH: begin
							if (n >= cap_use) begin
								fin     = 1'b1;
								res_ovf = 1'b1;
							end else if (back_q >= cap_use && front_q != '0) begin
								if (n == '0) begin
									// nothing live: append at slot zero
									mem_we    = 1'b1;
									wptr      = '0;
									mem_wdata = value;
									front_d   = '0;
									back_d    = PW'(1);
									fin       = 1'b1;
									res_size  = PW'(1);
								end else begin
									// start compaction down to slot zero
									mem_re    = 1'b1;
									rptr      = front_q;
									src_d     = front_q;
									dst_d     = '0;
									end_d     = back_q;
									compact_d = 1'b1;
									state_d   = ST_MOVE;
								end
							end else if (back_q < DEPTH_P) begin
								mem_we    = 1'b1;
								wptr      = back_q;
								mem_wdata = value;
								back_d    = back_q + PW'(1);
								fin       = 1'b1;
								res_size  = n + PW'(1);
							end else begin
								fin     = 1'b1;
								res_ovf = 1'b1;
							end
						end
						OP_POP_FRONT, OP_PEEK_FRONT: begin
							if (n != '0) begin
								mem_re  = 1'b1;
								rptr    = front_q;
								state_d = ST_READ;
								if (func == OP_POP_FRONT) begin
									front_d = front_q + PW'(1);
									rsize_d = n - PW'(1);
								end else begin
									rsize_d = n;
								end
							end else begin
								fin = 1'b1;
							end
						end
						OP_POP_BACK, OP_PEEK_BACK: begin
							if (n != '0) begin
								mem_re  = 1'b1;
								rptr    = back_q - PW'(1);
								state_d = ST_READ;
								if (func == OP_POP_BACK) begin
									back_d  = back_q - PW'(1);
									rsize_d = n - PW'(1);
								end else begin
									rsize_d = n;
								end
							end else begin
								fin = 1'b1;
							end
						end
						OP_GET: begin
							if (idx_ok) begin
								mem_re  = 1'b1;
								rptr    = idx_addr;
								rsize_d = n;
								state_d = ST_READ;
							end else begin
								fin = 1'b1;
							end
						end
						OP_DELETE: begin
							if (!idx_ok) begin
								fin = 1'b1;
							end else if (idx_ext + CW'(1) == n_ext) begin
								// last entry: no shift needed
								back_d    = back_q - PW'(1);
								fin       = 1'b1;
								res_valid = 1'b1;
								res_size  = n - PW'(1);
							end else begin
								mem_re    = 1'b1;
								rptr      = del_src;
								src_d     = del_src;
								dst_d     = idx_addr;
								end_d     = back_q;
								compact_d = 1'b0;
								state_d   = ST_MOVE;
							end
						end
						OP_CONTAINS: begin
							if (n != '0) begin
								mem_re  = 1'b1;
								rptr    = front_q;
								src_d   = front_q;
								end_d   = back_q;
								state_d = ST_SCAN;
							end else begin
								fin = 1'b1;
							end
						end
						OP_CLEAR: begin
							front_d  = '0;
							back_d   = '0;
							fin      = 1'b1;
							res_size = '0;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				fin       = 1'b1;
				res_data  = mem_rdata_s1;
				res_valid = 1'b1;
				res_size  = rsize_q;
			end
			ST_MOVE: begin
				// write the word read last cycle, read the next one
				mem_we    = 1'b1;
				wptr      = dst_q;
				mem_wdata = mem_rdata_s1;
				dst_d     = dst_q + PW'(1);
				if (src_q + PW'(1) < end_q) begin
					mem_re = 1'b1;
					rptr   = src_q + PW'(1);
					src_d  = src_q + PW'(1);
				end else if (compact_q) begin
					front_d = '0;
					back_d  = dst_q + PW'(1);
					state_d = ST_APPEND;
				end else begin
					back_d    = back_q - PW'(1);
					fin       = 1'b1;
					res_valid = 1'b1;
					res_size  = n - PW'(1);
				end
			end
			ST_APPEND: begin
				mem_we    = 1'b1;
				wptr      = back_q;
				mem_wdata = val_q;
				back_d    = back_q + PW'(1);
				fin       = 1'b1;
				res_size  = back_q + PW'(1);
			end
			ST_SCAN: begin
				if (mem_rdata_s1 == val_q) begin
					fin       = 1'b1;
					res_valid = 1'b1;
				end else if (src_q + PW'(1) < end_q) begin
					mem_re = 1'b1;
					rptr   = src_q + PW'(1);
					src_d  = src_q + PW'(1);
				end else begin
					fin = 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// Park the result when the output register is still held
		if (fin) begin
			state_d = out_free ? ST_IDLE : ST_DONE;
		end
	end

	assign load_out  = out_free && (fin || state_q == ST_DONE);
	assign load_pend = fin && !out_free;

	// State and pointer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			front_q     <= '0;
			back_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			back_q  <= back_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working and result payload registers
	always_ff @(posedge clk) begin
		val_q     <= val_d;
		src_q     <= src_d;
		dst_q     <= dst_d;
		end_q     <= end_d;
		compact_q <= compact_d;
		rsize_q   <= rsize_d;
		if (load_pend) begin
			pend_data_q <= res_data;
			pend_vres_q <= res_valid;
			pend_ovf_q  <= res_ovf;
			pend_size_q <= res_size;
		end
		if (load_out) begin
			out_data_q <= fin ? res_data : pend_data_q;
			out_vres_q <= fin ? res_valid : pend_vres_q;
			out_ovf_q  <= fin ? res_ovf : pend_ovf_q;
			out_size_q <= fin ? res_size : pend_size_q;
		end
	end

	// Slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wptr[AW-1:0]] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_s1 <= mem[rptr[AW-1:0]];
		end
	end

	// Capacity register
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr && paddr[APB_ADDR_W-1:2] == REG_CAPACITY) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[APB_ADDR_W-1:2] == REG_CAPACITY) ? APB_DATA_W'(cap_q) : '0;

	// Result outputs
	assign out_valid = out_valid_q;
	assign data      = out_data_q;
	assign valid_res = out_vres_q;
	assign overflow  = out_ovf_q;
	assign size      = SIZE_W'(out_size_q);
	assign is_empty  = (out_size_q == '0);

endmodule

>>> design/iqsl_checker.sv
// Port-level checks for the indexed queue/stack/list unit, bound to the top level.
// Depends on iqsl_pkg for field widths.
module iqsl_checker
	import iqsl_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DATA_W-1:0] data,
	input logic              valid_res,
	input logic              overflow,
	input logic [SIZE_W-1:0] size,
	input logic              is_empty
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data) && $stable(size))
		else $error("result changed while stalled");

	// Empty flag tracks the live count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (size == '0)))
		else $error("is_empty disagrees with size");

	// A refused push returns no data and no valid mark
	a_ovf_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> !valid_res && data == '0)
		else $error("overflow with data or valid_res");

	// Refusal only happens with a non-empty store
	a_ovf_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> !is_empty)
		else $error("overflow reported on empty store");

endmodule

bind indexed_queue_stack_list_unit iqsl_checker u_iqsl_checker (.*);

>>> dv/testbench.sv
// Self-checking testbench for indexed_queue_stack_list_unit: directed and random requests,
// each checked against a local deque model of the slot store, pointers and capacity.
// Depends on iqsl_pkg and the RTL top level only.
module testbench;
	import iqsl_pkg::*;

	localparam int RUN_LIMIT = 3_000_000;
	localparam int DRAIN_CYCLES = 300;
	localparam int REPORT_MAX = 10;
	localparam logic [FUNC_W-1:0] FUNC_NOP_FIRST = FUNC_W'(OP_CLEAR + 1);
	localparam logic [FUNC_W-1:0] FUNC_NOP_LAST = '1;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              valid_res;
		logic              overflow;
		logic [SIZE_W-1:0] size;
		logic              is_empty;
	} result_t;

	typedef enum logic [1:0] {
		RDY_ALWAYS,
		RDY_RANDOM,
		RDY_PATTERN,
		RDY_SPARSE
	} ready_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [FUNC_W-1:0]     func = '0;
	logic [DATA_W-1:0]     value = '0;
	logic [INDEX_W-1:0]    index = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [DATA_W-1:0]     data;
	logic                  valid_res;
	logic                  overflow;
	logic [SIZE_W-1:0]     size;
	logic                  is_empty;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// Shadow of the deque state
	logic [DATA_W-1:0] shadow_slots [DEPTH_DEF];
	int unsigned       shadow_front = 0;
	int unsigned       shadow_back = 0;
	logic [CAP_W-1:0]  shadow_cap = CAP_RESET;

	result_t     due_results [$];
	int          bad_results = 0;
	int          cycle_count = 0;
	int          burst_left = 0;
	bit          filling = 1'b1;
	ready_mode_t ready_mode = RDY_ALWAYS;
	int          mode_timer = 0;
	logic [7:0]  ready_pattern = 8'hFF;

	// Operation mix: cumulative cut points over op_order, the rest are unused codes
	op_t op_order [9] = '{OP_PUSH, OP_POP_FRONT, OP_PEEK_FRONT, OP_POP_BACK, OP_PEEK_BACK,
		OP_GET, OP_DELETE, OP_CONTAINS, OP_CLEAR};
	int fill_cuts [9] = '{80, 83, 85, 87, 89, 94, 96, 99, 99};
	int drain_cuts [9] = '{20, 40, 45, 57, 62, 74, 84, 94, 97};

	indexed_queue_stack_list_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.value     (value),
		.index     (index),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data      (data),
		.valid_res (valid_res),
		.overflow  (overflow),
		.size      (size),
		.is_empty  (is_empty),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #10 clk = ~clk;

	// Clamp the capacity register to the usable range
	function automatic int unsigned usable_cap();
		if (shadow_cap == 0)
			return 1;
		if (shadow_cap > DEPTH_DEF)
			return DEPTH_DEF;
		return shadow_cap;
	endfunction

	// Apply one request to the shadow deque and return its result
	function automatic result_t run_deque_op(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] v,
		logic [INDEX_W-1:0] idx);
		result_t     r;
		int unsigned lim;
		int unsigned live;
		r = '0;
		lim = usable_cap();
		live = shadow_back - shadow_front;
		case (f)
			OP_PUSH: begin
				if (live >= lim) begin
					r.overflow = 1'b1;
				end else begin
					// compact live entries down to slot zero first
					if (shadow_back >= lim && shadow_front > 0) begin
						for (int k = 0; k < live; k++)
							shadow_slots[k] = shadow_slots[shadow_front + k];
						shadow_back = live;
						shadow_front = 0;
					end
					if (shadow_back < DEPTH_DEF) begin
						shadow_slots[shadow_back] = v;
						shadow_back++;
					end else begin
						r.overflow = 1'b1;
					end
				end
			end
			OP_POP_FRONT, OP_PEEK_FRONT: begin
				if (live > 0) begin
					r.data = shadow_slots[shadow_front];
					r.valid_res = 1'b1;
					if (f == OP_POP_FRONT)
						shadow_front++;
				end
			end
			OP_POP_BACK, OP_PEEK_BACK: begin
				if (live > 0) begin
					r.data = shadow_slots[shadow_back - 1];
					r.valid_res = 1'b1;
					if (f == OP_POP_BACK)
						shadow_back--;
				end
			end
			OP_GET: begin
				if (idx < live) begin
					r.data = shadow_slots[shadow_front + idx];
					r.valid_res = 1'b1;
				end
			end
			OP_DELETE: begin
				if (idx < live) begin
					for (int k = idx + 1; k < live; k++)
						shadow_slots[shadow_front + k - 1] = shadow_slots[shadow_front + k];
					shadow_back--;
					r.valid_res = 1'b1;
				end
			end
			OP_CONTAINS: begin
				for (int k = 0; k < live && !r.valid_res; k++)
					if (shadow_slots[shadow_front + k] == v)
						r.valid_res = 1'b1;
			end
			OP_CLEAR: begin
				shadow_front = 0;
				shadow_back = 0;
			end
			default: begin
			end
		endcase
		live = shadow_back - shadow_front;
		r.size = live[SIZE_W-1:0];
		r.is_empty = (live == 0);
		return r;
	endfunction

	// Pick a word with extremes and small values weighted in
	function automatic logic [DATA_W-1:0] rand_word();
		case ($urandom_range(0, 3))
			0, 1: return $urandom;
			2: return $urandom_range(0, 15);
			default: return $urandom_range(0, 1) ? '1 : '0;
		endcase
	endfunction

	// Drop valid between bursts, sometimes run a burst with no gap
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
	endtask

	// Drive one request, wait for acceptance, record its expected result
	task automatic send_request(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] v,
		logic [INDEX_W-1:0] idx);
		in_valid <= 1'b1;
		func <= f;
		value <= v;
		index <= idx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		due_results.push_back(run_deque_op(f, v, idx));
		pace_sender();
	endtask

	// Drop valid and wait until every outstanding result has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	// Write the capacity register through setup and access phases
	task automatic write_capacity(logic [CAP_W-1:0] cap_word);
		logic [APB_DATA_W-1:0] wdata;
		wdata = {APB_DATA_W'($urandom)} & ~APB_DATA_W'({CAP_W{1'b1}});
		wdata[CAP_W-1:0] = cap_word;
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_CAPACITY, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		shadow_cap = cap_word;
	endtask

	// Empty store, hits, misses, every operation and the unused codes
	task automatic test_directed_ops();
		send_request(OP_POP_FRONT, 32'h0, 8'h00);
		send_request(OP_PEEK_BACK, 32'h0, 8'h00);
		send_request(OP_GET, 32'h0, 8'h00);
		send_request(OP_DELETE, 32'h0, 8'h00);
		send_request(OP_PUSH, 32'h0000_0000, 8'hFF);
		send_request(OP_PUSH, 32'hFFFF_FFFF, 8'h00);
		send_request(OP_PUSH, 32'h5A5A_A5A5, 8'h00);
		send_request(OP_PUSH, 32'h0000_0001, 8'h00);
		send_request(OP_PEEK_FRONT, 32'h0, 8'h00);
		send_request(OP_POP_FRONT, 32'h0, 8'h00);
		send_request(OP_PEEK_BACK, 32'h0, 8'h00);
		send_request(OP_GET, 32'h0, 8'h02);
		send_request(OP_GET, 32'h0, 8'hFF);
		send_request(OP_CONTAINS, 32'hFFFF_FFFF, 8'h00);
		send_request(OP_CONTAINS, 32'h1234_5678, 8'h00);
		send_request(OP_DELETE, 32'h0, 8'h01);
		send_request(OP_DELETE, 32'h0, 8'hC8);
		send_request(OP_POP_BACK, 32'h0, 8'h00);
		send_request(FUNC_NOP_FIRST, 32'hDEAD_BEEF, 8'h00);
		send_request(FUNC_NOP_LAST, 32'hFFFF_FFFF, 8'hFF);
		send_request(OP_CLEAR, 32'h0, 8'h00);
	endtask

	// Capacity of zero, full store, and capacity lowered below the back
	task automatic test_capacity_edges();
		write_capacity('0);
		send_request(OP_PUSH, 32'hA000_0001, 8'h00);
		send_request(OP_PUSH, 32'hA000_0002, 8'h00);
		write_capacity(CAP_RESET);
		for (int k = 0; k < 4; k++)
			send_request(OP_PUSH, 32'hB000_0000 + k, 8'h00);
		for (int k = 0; k < 3; k++)
			send_request(OP_POP_FRONT, 32'h0, 8'h00);
		write_capacity(9'd3);
		send_request(OP_PUSH, 32'hC000_0001, 8'h00);
		send_request(OP_PUSH, 32'hC000_0002, 8'h00);
	endtask

	// Random traffic that alternates between filling and draining the store
	task automatic test_random_phase(logic [CAP_W-1:0] cap_word, int n_items);
		int unsigned       live;
		int                roll;
		logic [FUNC_W-1:0] f;
		logic [DATA_W-1:0] v;
		logic [INDEX_W-1:0] idx;
		write_capacity(cap_word);
		for (int i = 0; i < n_items; i++) begin
			live = shadow_back - shadow_front;
			if (live == 0)
				filling = 1'b1;
			else if (live >= usable_cap())
				filling = 1'b0;
			else if (!filling && $urandom_range(0, 29) == 0)
				filling = 1'b1;
			roll = $urandom_range(0, 99);
			f = FUNC_W'($urandom_range(FUNC_NOP_FIRST, FUNC_NOP_LAST));
			for (int k = 8; k >= 0; k--)
				if (roll < (filling ? fill_cuts[k] : drain_cuts[k]))
					f = op_order[k];
			v = rand_word();
			if (f == OP_CONTAINS && live > 0 && $urandom_range(0, 4) < 3)
				v = shadow_slots[shadow_front + $urandom_range(0, live - 1)];
			idx = INDEX_W'($urandom_range(0, 255));
			if ((f == OP_GET || f == OP_DELETE) && live > 0 && $urandom_range(0, 99) < 85)
				idx = INDEX_W'($urandom_range(0, live - 1));
			send_request(f, v, idx);
		end
	endtask

	// Receiver: stall on a pattern that changes mode now and then
	always @(posedge clk) begin
		if (mode_timer == 0) begin
			ready_mode <= ready_mode_t'($urandom_range(0, 3));
			mode_timer <= $urandom_range(50, 300);
			ready_pattern <= 8'($urandom) | 8'h01;
		end else begin
			mode_timer <= mode_timer - 1;
			if (ready_mode == RDY_PATTERN)
				ready_pattern <= {ready_pattern[0], ready_pattern[7:1]};
		end
		case (ready_mode)
			RDY_ALWAYS: out_ready <= 1'b1;
			RDY_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
			RDY_PATTERN: out_ready <= ready_pattern[0];
			default: out_ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{data, valid_res, overflow, size, is_empty};
			if (due_results.size() == 0) begin
				bad_results++;
				if (bad_results <= REPORT_MAX)
					$display("unexpected result: data %h valid_res %b overflow %b size %0d is_empty %b",
						got.data, got.valid_res, got.overflow, got.size, got.is_empty);
			end else begin
				want = due_results.pop_front();
				if (got !== want) begin
					bad_results++;
					if (bad_results <= REPORT_MAX)
						$display("result mismatch: expected data %h valid_res %b overflow %b size %0d is_empty %b, got data %h valid_res %b overflow %b size %0d is_empty %b",
							want.data, want.valid_res, want.overflow, want.size, want.is_empty,
							got.data, got.valid_res, got.overflow, got.size, got.is_empty);
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_ops();
		test_capacity_edges();
		test_random_phase(9'd8, 300);
		test_random_phase(9'd1, 80);
		test_random_phase(9'd2, 80);
		test_random_phase(9'd511, 450);
		for (int k = 0; k < 3; k++)
			test_random_phase(CAP_W'($urandom_range(0, 63)), 70);
		test_random_phase(CAP_W'($urandom_range(DEPTH_DEF + 1, 511)), 70);
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		bad_results += due_results.size();
		if (bad_results == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
